// ===== design/sma_pkg.sv =====
// ----------------------------------------------------------------------------
// sma_pkg
// Shared constants, types and helpers for the sliding window average block.
// ----------------------------------------------------------------------------
`default_nettype none

package sma_pkg;

    localparam int WINDOW_MAX    = 64;
    localparam int FRACTION_BITS = 8;

    localparam int SAMPLE_W = 16;
    localparam int AVG_W    = 24;
    localparam int HELD_W   = 7;
    localparam int CFG_W    = 7;

    localparam int PTR_W      = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int CNT_W      = $clog2(WINDOW_MAX + 1);
    localparam int SUM_W      = SAMPLE_W + PTR_W + 1;
    localparam int DIVIDEND_W = SUM_W + FRACTION_BITS;
    localparam int DIV_CNT_W  = $clog2(DIVIDEND_W);

    typedef struct packed {
        logic             we;
        logic [PTR_W-1:0] waddr;
        logic             re;
        logic [PTR_W-1:0] raddr;
    } ring_ctl_t;

    typedef struct packed {
        logic start;
        logic negate;
    } div_ctl_t;

    function automatic logic [CNT_W-1:0] eff_window(input logic [CFG_W-1:0] ws);
        logic [CNT_W-1:0] w;
        if (ws == '0) begin
            w = CNT_W'(1);
        end else if (32'(ws) > WINDOW_MAX) begin
            w = CNT_W'(WINDOW_MAX);
        end else begin
            w = CNT_W'(ws);
        end
        return w;
    endfunction

    function automatic logic [PTR_W-1:0] ring_wrap(input logic [PTR_W-1:0] base,
                                                   input logic [CNT_W-1:0] offs);
        logic [CNT_W:0] t;
        t = (CNT_W+1)'(base) + (CNT_W+1)'(offs);
        if (t >= (CNT_W+1)'(WINDOW_MAX)) begin
            t = t - (CNT_W+1)'(WINDOW_MAX);
        end
        return t[PTR_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== design/sma_ring.sv =====
// ----------------------------------------------------------------------------
// sma_ring
// Sample ring buffer: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module sma_ring (
    input  wire logic                           aclk,
    input  wire sma_pkg::ring_ctl_t             ctl,
    input  wire logic [sma_pkg::SAMPLE_W-1:0]   wr_data,
    output logic      [sma_pkg::SAMPLE_W-1:0]   rd_data
);

    logic [sma_pkg::SAMPLE_W-1:0] mem [sma_pkg::WINDOW_MAX];

    always_ff @(posedge aclk) begin
        if (ctl.we) begin
            mem[ctl.waddr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.re) begin
            rd_data <= mem[ctl.raddr];
        end
    end

endmodule

`default_nettype wire

// ===== design/sma_div.sv =====
// ----------------------------------------------------------------------------
// sma_div
// Bit-serial restoring divider: one quotient bit per cycle, sign fixup last.
// ----------------------------------------------------------------------------
`default_nettype none

module sma_div (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire sma_pkg::div_ctl_t                ctl,
    input  wire logic [sma_pkg::DIVIDEND_W-1:0]   dividend,
    input  wire logic [sma_pkg::CNT_W-1:0]        divisor,
    output logic                                  done,
    output logic      [sma_pkg::AVG_W-1:0]        quotient
);

    localparam int DW = sma_pkg::DIVIDEND_W;
    localparam int CW = sma_pkg::CNT_W;
    localparam int KW = sma_pkg::DIV_CNT_W;

    typedef enum logic [2:0] {
        D_IDLE = 3'b001,
        D_RUN  = 3'b010,
        D_FIX  = 3'b100
    } div_state_t;

    div_state_t    state_reg, state_next;
    logic [DW-1:0] dq_reg, dq_next;
    logic [CW-1:0] rem_reg, rem_next;
    logic [CW-1:0] dvsr_reg, dvsr_next;
    logic          neg_reg, neg_next;
    logic [KW-1:0] cnt_reg, cnt_next;
    logic [sma_pkg::AVG_W-1:0] quot_reg, quot_next;
    logic          done_reg, done_next;

    logic [CW:0]   rem_shift;
    logic          ge;
    logic [DW-1:0] q_signed;

    assign rem_shift = {rem_reg, dq_reg[DW-1]};
    assign ge        = rem_shift >= {1'b0, dvsr_reg};
    assign q_signed  = neg_reg ? (~dq_reg + DW'(1)) : dq_reg;

    always_comb begin
        state_next = state_reg;
        dq_next    = dq_reg;
        rem_next   = rem_reg;
        dvsr_next  = dvsr_reg;
        neg_next   = neg_reg;
        cnt_next   = cnt_reg;
        quot_next  = quot_reg;
        done_next  = 1'b0;
        case (state_reg)
            D_IDLE: begin
                if (ctl.start) begin
                    dq_next    = dividend;
                    rem_next   = '0;
                    dvsr_next  = divisor;
                    neg_next   = ctl.negate;
                    cnt_next   = KW'(DW - 1);
                    state_next = D_RUN;
                end
            end
            D_RUN: begin
                rem_next = ge ? CW'(rem_shift - {1'b0, dvsr_reg}) : CW'(rem_shift);
                dq_next  = {dq_reg[DW-2:0], ge};
                cnt_next = cnt_reg - KW'(1);
                if (cnt_reg == '0) begin
                    state_next = D_FIX;
                end
            end
            D_FIX: begin
                quot_next  = q_signed[sma_pkg::AVG_W-1:0];
                done_next  = 1'b1;
                state_next = D_IDLE;
            end
            default: begin
                state_next = D_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= D_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        dq_reg   <= dq_next;
        rem_reg  <= rem_next;
        dvsr_reg <= dvsr_next;
        neg_reg  <= neg_next;
        cnt_reg  <= cnt_next;
        quot_reg <= quot_next;
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule

`default_nettype wire

// ===== design/sliding_window_average.sv =====
// ----------------------------------------------------------------------------
// sliding_window_average
// Moving average over the most recent samples of a programmable window.
// ----------------------------------------------------------------------------
// Input channel s_valid/s_ready carries one signed sample per transaction;
// output channel m_valid/m_ready returns one transaction per sample: the mean
// of the held samples (8 fraction bits, truncated toward zero) and the count
// of samples held. cfg_wr_en/cfg_wr_data write the window length (0 acts as 1,
// values above 64 act as 64) and empty the window; write only while idle.
// From input acceptance to m_valid a sample passes through the sum update,
// divider load, the serial divider (one quotient bit per cycle over 31 bits,
// sum width plus fraction bits), sign fixup and output register load. One
// item is in flight at a time; s_ready is high only in the idle state.
// The output register holds a finished result while the next sample is
// accepted; if m_ready stays low the finished quotient waits in the divider
// and no further sample is accepted until the output register frees up.
// Reset (aresetn low, synchronous) empties the window and sets the window
// length to 3. The ring memory is not cleared; read data is used only from
// written entries.
// ----------------------------------------------------------------------------
`default_nettype none

module sliding_window_average (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_wr_en,
    input  wire logic        [sma_pkg::CFG_W-1:0]    cfg_wr_data,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic signed [sma_pkg::SAMPLE_W-1:0] s_sample,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic signed      [sma_pkg::AVG_W-1:0]    m_average,
    output logic             [sma_pkg::HELD_W-1:0]   m_samples_held
);

    localparam int SW = sma_pkg::SUM_W;
    localparam int CW = sma_pkg::CNT_W;
    localparam int PW = sma_pkg::PTR_W;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_UPDATE = 5'b00010,
        ST_START  = 5'b00100,
        ST_WAIT   = 5'b01000,
        ST_DONE   = 5'b10000
    } sma_state_t;

    sma_state_t state_reg, state_next;
    logic [sma_pkg::CFG_W-1:0]           window_reg, window_next;
    logic signed [SW-1:0]                sum_reg, sum_next;
    logic [CW-1:0]                       fill_reg, fill_next;
    logic [PW-1:0]                       oldest_reg, oldest_next;
    logic signed [sma_pkg::SAMPLE_W-1:0] sample_reg, sample_next;
    logic                                m_valid_reg, m_valid_next;
    logic [sma_pkg::AVG_W-1:0]           avg_reg, avg_next;
    logic [sma_pkg::HELD_W-1:0]          held_reg, held_next;

    sma_pkg::ring_ctl_t              ring_ctl;
    logic [sma_pkg::SAMPLE_W-1:0]    ring_rd_data;
    sma_pkg::div_ctl_t               div_ctl;
    logic [sma_pkg::DIVIDEND_W-1:0]  div_dividend;
    logic                            div_done;
    logic [sma_pkg::AVG_W-1:0]       div_quot;

    logic [CW-1:0]        eff_w;
    logic                 full;
    logic signed [SW-1:0] drop;
    logic [SW-1:0]        sum_mag;
    logic                 s_accept;
    logic                 out_free;

    assign eff_w    = sma_pkg::eff_window(window_reg);
    assign full     = (fill_reg == eff_w);
    assign drop     = full ? SW'(signed'(ring_rd_data)) : '0;
    assign s_accept = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign sum_mag  = sum_reg[SW-1] ? (~sum_reg + SW'(1)) : sum_reg;
    assign div_dividend = sma_pkg::DIVIDEND_W'(sum_mag) << sma_pkg::FRACTION_BITS;

    always_comb begin
        ring_ctl.we    = (state_reg == ST_UPDATE);
        ring_ctl.waddr = sma_pkg::ring_wrap(oldest_reg, fill_reg);
        ring_ctl.re    = s_accept;
        ring_ctl.raddr = oldest_reg;
        div_ctl.start  = (state_reg == ST_START);
        div_ctl.negate = sum_reg[SW-1];
    end

    always_comb begin
        state_next   = state_reg;
        window_next  = window_reg;
        sum_next     = sum_reg;
        fill_next    = fill_reg;
        oldest_next  = oldest_reg;
        sample_next  = sample_reg;
        avg_next     = avg_reg;
        held_next    = held_reg;
        m_valid_next = m_valid_reg && !m_ready;
        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    sample_next = s_sample;
                    state_next  = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                sum_next = sum_reg - drop + SW'(sample_reg);
                if (full) begin
                    oldest_next = sma_pkg::ring_wrap(oldest_reg, CW'(1));
                end else begin
                    fill_next = fill_reg + CW'(1);
                end
                state_next = ST_START;
            end
            ST_START: begin
                state_next = ST_WAIT;
            end
            ST_WAIT, ST_DONE: begin
                if ((div_done || state_reg == ST_DONE) && out_free) begin
                    avg_next     = div_quot;
                    held_next    = sma_pkg::HELD_W'(fill_reg);
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end else if (div_done) begin
                    state_next = ST_DONE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
        if (cfg_wr_en) begin
            window_next = cfg_wr_data;
            sum_next    = '0;
            fill_next   = '0;
            oldest_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            window_reg  <= sma_pkg::CFG_W'(3);
            sum_reg     <= '0;
            fill_reg    <= '0;
            oldest_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            window_reg  <= window_next;
            sum_reg     <= sum_next;
            fill_reg    <= fill_next;
            oldest_reg  <= oldest_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        sample_reg <= sample_next;
        avg_reg    <= avg_next;
        held_reg   <= held_next;
    end

    sma_ring u_ring (
        .aclk    (aclk),
        .ctl     (ring_ctl),
        .wr_data (sample_reg),
        .rd_data (ring_rd_data)
    );

    sma_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (div_ctl),
        .dividend (div_dividend),
        .divisor  (fill_reg),
        .done     (div_done),
        .quotient (div_quot)
    );

    assign s_ready        = (state_reg == ST_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_average      = avg_reg;
    assign m_samples_held = held_reg;

`ifndef NO_ASSERTIONS
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= eff_w)
        else $error("fill count exceeds window");

    a_accept_update: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && !cfg_wr_en |=> state_reg == ST_UPDATE)
        else $error("accepted sample did not start update");

    a_held_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> held_reg != '0)
        else $error("result with empty window");

    a_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> state_reg == ST_WAIT)
        else $error("divider finished outside wait state");
`endif

endmodule

`default_nettype wire
